>>> rtl/mm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int SIZE_W      = 4;
    localparam int PROD_W      = 2 * VALUE_BITS;
    localparam int ACC_W       = 35;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ROWS_A     = 2'd0,
        REG_INNER_SIZE = 2'd1,
        REG_COLS_B     = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        OP_LOAD_A,
        OP_LOAD_B,
        OP_COMPUTE
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [ADDR_W-1:0]     addr;
        logic [VALUE_BITS-1:0] value;
    } t_item;

    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] inner;
        logic [SIZE_W-1:0] cols;
    } t_sizes;

    // clamp a size register to 1..MAX_DIM
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_DIM)) begin
            r = SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/mm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mm_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire mm_pkg::t_item  i_item,
    input  wire                 i_pop,
    output mm_pkg::t_item       o_head,
    output logic                o_empty,
    output logic                o_full
);

    mm_pkg::t_item              r_slot [mm_pkg::QUEUE_DEPTH];
    logic [mm_pkg::QPTR_W-1:0]  r_wptr;
    logic [mm_pkg::QPTR_W-1:0]  r_rptr;
    logic [mm_pkg::QPTR_W:0]    r_count;

    assign o_head  = r_slot[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (mm_pkg::QPTR_W + 1)'(mm_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/mm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mm_front (
    input  wire                          i_valid,
    input  wire [1:0]                    i_cmd,
    input  wire [mm_pkg::IDX_W-1:0]      i_elem_row,
    input  wire [mm_pkg::IDX_W-1:0]      i_elem_col,
    input  wire signed [15:0]            i_elem_value,
    input  wire mm_pkg::t_sizes          i_sizes,
    input  wire                          i_full,
    output logic                         o_stall,
    output logic                         o_push,
    output mm_pkg::t_item                o_item
);

    logic in_a;
    logic in_b;
    logic keep;

    assign in_a = ({1'b0, i_elem_row} < i_sizes.rows) && ({1'b0, i_elem_col} < i_sizes.inner);
    assign in_b = ({1'b0, i_elem_row} < i_sizes.inner) && ({1'b0, i_elem_col} < i_sizes.cols);

    // drop out-of-range loads and the unused command: accepted, never queued
    always_comb begin
        keep       = 1'b0;
        o_item.op  = mm_pkg::OP_COMPUTE;
        case (mm_pkg::t_cmd'(i_cmd))
            mm_pkg::CMD_LOAD_A: begin
                keep      = in_a;
                o_item.op = mm_pkg::OP_LOAD_A;
            end
            mm_pkg::CMD_LOAD_B: begin
                keep      = in_b;
                o_item.op = mm_pkg::OP_LOAD_B;
            end
            mm_pkg::CMD_COMPUTE: begin
                keep      = 1'b1;
                o_item.op = mm_pkg::OP_COMPUTE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        o_item.addr  = {i_elem_row, i_elem_col};
        o_item.value = i_elem_value[mm_pkg::VALUE_BITS-1:0];
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && keep;

endmodule

`default_nettype wire

>>> rtl/mm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mm_back (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire mm_pkg::t_sizes               i_sizes,
    input  wire mm_pkg::t_item                i_head,
    input  wire                               i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic [mm_pkg::IDX_W-1:0]          o_out_row,
    output logic [mm_pkg::IDX_W-1:0]          o_out_col,
    output logic signed [mm_pkg::ACC_W-1:0]   o_out_value,
    output logic                              o_out_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state                                 r_state;
    logic [mm_pkg::IDX_W-1:0]               r_i;
    logic [mm_pkg::IDX_W-1:0]               r_j;
    logic [mm_pkg::IDX_W-1:0]               r_k;
    logic [mm_pkg::STORE_DEPTH-1:0]         r_valid_a;
    logic [mm_pkg::STORE_DEPTH-1:0]         r_valid_b;

    logic                                   r_p1_valid;
    logic                                   r_p1_first;
    logic                                   r_p1_last;
    logic                                   r_p1_hit_a;
    logic                                   r_p1_hit_b;
    logic                                   r_p2_valid;
    logic                                   r_p2_first;
    logic                                   r_p2_last;
    logic signed [mm_pkg::PROD_W-1:0]       r_prod;
    logic signed [mm_pkg::ACC_W-1:0]        r_acc;

    logic                                   r_out_valid;
    logic [mm_pkg::IDX_W-1:0]               r_out_row;
    logic [mm_pkg::IDX_W-1:0]               r_out_col;
    logic signed [mm_pkg::ACC_W-1:0]        r_out_value;
    logic                                   r_out_last;

    logic                                   we_a;
    logic                                   we_b;
    logic [mm_pkg::ADDR_W-1:0]              raddr_a;
    logic [mm_pkg::ADDR_W-1:0]              raddr_b;
    logic [mm_pkg::VALUE_BITS-1:0]          rdata_a;
    logic [mm_pkg::VALUE_BITS-1:0]          rdata_b;
    logic signed [mm_pkg::VALUE_BITS-1:0]   op_a;
    logic signed [mm_pkg::VALUE_BITS-1:0]   op_b;
    logic signed [mm_pkg::PROD_W-1:0]       n_prod;
    logic signed [mm_pkg::ACC_W-1:0]        n_acc;
    logic                                   issue;
    logic                                   k_last;
    logic                                   j_last;
    logic                                   i_last;
    logic                                   emit;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign we_a    = o_pop && (i_head.op == mm_pkg::OP_LOAD_A);
    assign we_b    = o_pop && (i_head.op == mm_pkg::OP_LOAD_B);
    assign raddr_a = {r_i, r_k};
    assign raddr_b = {r_k, r_j};

    // issue only into an empty output slot; it stays empty until this element lands
    assign issue  = (r_state == S_ISSUE) && !r_out_valid;
    assign k_last = ({1'b0, r_k} == (i_sizes.inner - 1'b1));
    assign j_last = ({1'b0, r_j} == (i_sizes.cols - 1'b1));
    assign i_last = ({1'b0, r_i} == (i_sizes.rows - 1'b1));
    assign emit   = r_p2_valid && r_p2_last;

    // entries never loaded since reset read as zero
    assign op_a   = r_p1_hit_a ? signed'(rdata_a) : '0;
    assign op_b   = r_p1_hit_b ? signed'(rdata_b) : '0;
    assign n_prod = op_a * op_b;
    assign n_acc  = (r_p2_first ? '0 : r_acc) + mm_pkg::ACC_W'(r_prod);

    mm_ram #(
        .WIDTH (mm_pkg::VALUE_BITS),
        .DEPTH (mm_pkg::STORE_DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (i_head.addr),
        .i_wdata (i_head.value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mm_ram #(
        .WIDTH (mm_pkg::VALUE_BITS),
        .DEPTH (mm_pkg::STORE_DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (i_head.addr),
        .i_wdata (i_head.value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_valid_a   <= '0;
            r_valid_b   <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_head.op == mm_pkg::OP_COMPUTE)) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (issue) begin
                        if (k_last) begin
                            r_k     <= '0;
                            r_state <= S_WAIT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_WAIT: begin
                    // advance to the next element in row-major order
                    if (emit) begin
                        if (j_last) begin
                            r_j <= '0;
                            if (i_last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (we_a) begin
                r_valid_a[i_head.addr] <= 1'b1;
            end
            if (we_b) begin
                r_valid_b[i_head.addr] <= 1'b1;
            end

            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        r_p1_first <= (r_k == '0);
        r_p1_last  <= k_last;
        r_p1_hit_a <= r_valid_a[raddr_a];
        r_p1_hit_b <= r_valid_b[raddr_b];
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_prod     <= n_prod;
        if (r_p2_valid) begin
            r_acc <= n_acc;
        end
        if (emit) begin
            r_out_row   <= r_i;
            r_out_col   <= r_j;
            r_out_value <= n_acc;
            r_out_last  <= i_last && j_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/matrix_multiply.sv
// Fixed-point matrix product C = A x B, elements signed Q8.8, results Q19.16.
// Request channel (i_valid / o_stall): cmd 0 writes A(row,col), cmd 1 writes
// B(row,col), cmd 2 computes; cmd 3 and loads outside the configured sizes
// are taken and dropped. A request is taken when i_valid is high and o_stall
// is low. Requests pass through a 4-entry queue, so loads stream in one per
// cycle while the queue has room; o_stall rises only when the queue is full.
// Result channel (o_valid / i_stall): a compute emits rows_a x cols_b
// elements in row-major order, the last one with o_out_last set. Each
// element is a multiply-accumulate of inner_size products through one 16x16
// multiplier, one A and one B store read per cycle, then a pipeline drain
// through the store read, product and output registers; the next element
// starts only once the previous result has left the output slot. A stalled
// result holds on the ports and the engine waits; the request queue keeps
// filling meanwhile.
// Sizes (rows_a, inner_size, cols_b) sit on the APB port at 0x0, 0x4, 0x8;
// 0 acts as 1, above 8 acts as 8. Write them only while the block is idle.
// Reset sets all sizes to 8 and makes both stores read as zero at once.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire [1:0]                          i_cmd,
    input  wire [mm_pkg::IDX_W-1:0]            i_elem_row,
    input  wire [mm_pkg::IDX_W-1:0]            i_elem_col,
    input  wire signed [15:0]                  i_elem_value,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [mm_pkg::IDX_W-1:0]           o_out_row,
    output logic [mm_pkg::IDX_W-1:0]           o_out_col,
    output logic signed [mm_pkg::ACC_W-1:0]    o_out_value,
    output logic                               o_out_last,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [3:0]                          paddr,
    input  wire [31:0]                         pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [mm_pkg::SIZE_W-1:0] r_rows_a;
    logic [mm_pkg::SIZE_W-1:0] r_inner_size;
    logic [mm_pkg::SIZE_W-1:0] r_cols_b;

    mm_pkg::t_sizes sizes;
    mm_pkg::t_item  push_item;
    mm_pkg::t_item  head;
    logic           push;
    logic           pop;
    logic           empty;
    logic           full;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= mm_pkg::SIZE_RESET;
            r_inner_size <= mm_pkg::SIZE_RESET;
            r_cols_b     <= mm_pkg::SIZE_RESET;
        end else if (cfg_wr) begin
            case (mm_pkg::t_reg'(paddr[3:2]))
                mm_pkg::REG_ROWS_A:     r_rows_a     <= pwdata[mm_pkg::SIZE_W-1:0];
                mm_pkg::REG_INNER_SIZE: r_inner_size <= pwdata[mm_pkg::SIZE_W-1:0];
                mm_pkg::REG_COLS_B:     r_cols_b     <= pwdata[mm_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (mm_pkg::t_reg'(paddr[3:2]))
            mm_pkg::REG_ROWS_A:     prdata = 32'(r_rows_a);
            mm_pkg::REG_INNER_SIZE: prdata = 32'(r_inner_size);
            mm_pkg::REG_COLS_B:     prdata = 32'(r_cols_b);
            default:                prdata = '0;
        endcase
    end

    assign sizes.rows  = mm_pkg::eff_size(r_rows_a);
    assign sizes.inner = mm_pkg::eff_size(r_inner_size);
    assign sizes.cols  = mm_pkg::eff_size(r_cols_b);

    mm_front u_front (
        .i_valid      (i_valid),
        .i_cmd        (i_cmd),
        .i_elem_row   (i_elem_row),
        .i_elem_col   (i_elem_col),
        .i_elem_value (i_elem_value),
        .i_sizes      (sizes),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_item       (push_item)
    );

    mm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    mm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sizes     (sizes),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

endmodule

`default_nettype wire

>>> rtl/mm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mm_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               o_valid,
    input wire                               i_stall,
    input wire [mm_pkg::IDX_W-1:0]           o_out_row,
    input wire [mm_pkg::IDX_W-1:0]           o_out_col,
    input wire signed [mm_pkg::ACC_W-1:0]    o_out_value,
    input wire                               o_out_last,
    input wire                               psel,
    input wire                               penable,
    input wire                               pwrite,
    input wire [3:0]                         paddr,
    input wire [31:0]                        pwdata,
    input wire [31:0]                        prdata,
    input wire                               pready
);

    // reset empties the result slot
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value)
            && $stable(o_out_row) && $stable(o_out_col) && $stable(o_out_last))
        else $error("stalled result changed");

    // each element still needs its accumulate and drain, so results never arrive back to back
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("results delivered back to back");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("APB pready low");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr == 4'd0)
            |=> (paddr != 4'd0) || (prdata[3:0] == $past(pwdata[3:0])))
        else $error("rows_a readback mismatch");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_out_value (o_out_value),
    .o_out_last  (o_out_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

`default_nettype wire

>>> test/product_checker.sv
`timescale 1ns / 1ps

module product_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  logic [1:0]                      req_cmd,
    input  logic [mm_pkg::IDX_W-1:0]        req_row,
    input  logic [mm_pkg::IDX_W-1:0]        req_col,
    input  logic signed [15:0]              req_value,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  logic [mm_pkg::IDX_W-1:0]        res_row,
    input  logic [mm_pkg::IDX_W-1:0]        res_col,
    input  logic signed [mm_pkg::ACC_W-1:0] res_value,
    input  logic                            res_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output int                              fail_count,
    output int                              results_pending,
    output int                              request_count,
    output int                              product_count,
    output int                              element_count
);

    typedef struct packed {
        logic [mm_pkg::IDX_W-1:0] row;
        logic [mm_pkg::IDX_W-1:0] col;
        logic [mm_pkg::ACC_W-1:0] value;
        logic                     last;
    } t_element;

    t_element due_elements[$];

    logic signed [mm_pkg::VALUE_BITS-1:0] mat_a [mm_pkg::MAX_DIM][mm_pkg::MAX_DIM];
    logic signed [mm_pkg::VALUE_BITS-1:0] mat_b [mm_pkg::MAX_DIM][mm_pkg::MAX_DIM];
    logic [mm_pkg::SIZE_W-1:0] rows_reg;
    logic [mm_pkg::SIZE_W-1:0] inner_reg;
    logic [mm_pkg::SIZE_W-1:0] cols_reg;

    int fails    = 0;
    int requests = 0;
    int products = 0;
    int elements = 0;

    function automatic int clamp_dim(input logic [mm_pkg::SIZE_W-1:0] v);
        if (v == '0) return 1;
        if (v > mm_pkg::SIZE_W'(mm_pkg::MAX_DIM)) return mm_pkg::MAX_DIM;
        return int'(v);
    endfunction

    // queue every element of A x B in row-major order
    task automatic predict_product();
        int nr;
        int nk;
        int nc;
        longint acc;
        t_element e;
        nr = clamp_dim(rows_reg);
        nk = clamp_dim(inner_reg);
        nc = clamp_dim(cols_reg);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = 0;
                for (int k = 0; k < nk; k++) begin
                    acc += longint'(mat_a[i][k]) * longint'(mat_b[k][j]);
                end
                e.row   = mm_pkg::IDX_W'(i);
                e.col   = mm_pkg::IDX_W'(j);
                e.value = acc[mm_pkg::ACC_W-1:0];
                e.last  = (i == nr - 1) && (j == nc - 1);
                due_elements.push_back(e);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_element oldest;
        int nr;
        int nk;
        int nc;
        if (!i_rst_n) begin
            for (int i = 0; i < mm_pkg::MAX_DIM; i++) begin
                for (int j = 0; j < mm_pkg::MAX_DIM; j++) begin
                    mat_a[i][j] = '0;
                    mat_b[i][j] = '0;
                end
            end
            rows_reg  = mm_pkg::SIZE_RESET;
            inner_reg = mm_pkg::SIZE_RESET;
            cols_reg  = mm_pkg::SIZE_RESET;
            due_elements.delete();
        end else begin
            if (res_valid && !res_stall) begin
                elements++;
                if (due_elements.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected element: row %0d col %0d value %0d last %0b",
                                 res_row, res_col, res_value, res_last);
                    end
                end else begin
                    oldest = due_elements.pop_front();
                    if (res_row !== oldest.row || res_col !== oldest.col ||
                        res_value !== oldest.value || res_last !== oldest.last) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("element mismatch: expected row %0d col %0d",
                                     oldest.row, oldest.col,
                                     " value %0d last %0b,", $signed(oldest.value),
                                     oldest.last,
                                     " got row %0d col %0d value %0d last %0b",
                                     res_row, res_col, res_value, res_last);
                        end
                    end
                end
            end

            if (req_valid && !req_stall) begin
                requests++;
                nr = clamp_dim(rows_reg);
                nk = clamp_dim(inner_reg);
                nc = clamp_dim(cols_reg);
                case (mm_pkg::t_cmd'(req_cmd))
                    mm_pkg::CMD_LOAD_A: begin
                        if (int'(req_row) < nr && int'(req_col) < nk) begin
                            mat_a[req_row][req_col] = req_value;
                        end
                    end
                    mm_pkg::CMD_LOAD_B: begin
                        if (int'(req_row) < nk && int'(req_col) < nc) begin
                            mat_b[req_row][req_col] = req_value;
                        end
                    end
                    mm_pkg::CMD_COMPUTE: begin
                        products++;
                        predict_product();
                    end
                    default: ;
                endcase
            end

            if (psel && penable && pwrite && pready) begin
                case (mm_pkg::t_reg'(paddr[3:2]))
                    mm_pkg::REG_ROWS_A:     rows_reg  = pwdata[mm_pkg::SIZE_W-1:0];
                    mm_pkg::REG_INNER_SIZE: inner_reg = pwdata[mm_pkg::SIZE_W-1:0];
                    mm_pkg::REG_COLS_B:     cols_reg  = pwdata[mm_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count      <= fails;
        results_pending <= due_elements.size();
        request_count   <= requests;
        product_count   <= products;
        element_count   <= elements;
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS   = 360;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [15:0] Q_MIN = 16'h8000;
    localparam logic [15:0] Q_MAX = 16'h7FFF;

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_valid      = 1'b0;
    logic                             o_stall;
    logic [1:0]                       i_cmd        = mm_pkg::CMD_NONE;
    logic [mm_pkg::IDX_W-1:0]         i_elem_row   = '0;
    logic [mm_pkg::IDX_W-1:0]         i_elem_col   = '0;
    logic signed [15:0]               i_elem_value = '0;
    logic                             o_valid;
    logic                             i_stall      = 1'b0;
    logic [mm_pkg::IDX_W-1:0]         o_out_row;
    logic [mm_pkg::IDX_W-1:0]         o_out_col;
    logic signed [mm_pkg::ACC_W-1:0]  o_out_value;
    logic                             o_out_last;
    logic                             psel         = 1'b0;
    logic                             penable      = 1'b0;
    logic                             pwrite       = 1'b0;
    logic [3:0]                       paddr        = '0;
    logic [31:0]                      pwdata       = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    int fail_count;
    int results_pending;
    int request_count;
    int product_count;
    int element_count;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_hold       = 0;
    int idle_cycles   = 0;
    int live_items    = 0;
    int size_settings = 0;
    int dim_r         = mm_pkg::MAX_DIM;
    int dim_k         = mm_pkg::MAX_DIM;
    int dim_c         = mm_pkg::MAX_DIM;

    matrix_multiply dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_elem_row   (i_elem_row),
        .i_elem_col   (i_elem_col),
        .i_elem_value (i_elem_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_out_last   (o_out_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    product_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .req_valid       (i_valid),
        .req_stall       (o_stall),
        .req_cmd         (i_cmd),
        .req_row         (i_elem_row),
        .req_col         (i_elem_col),
        .req_value       (i_elem_value),
        .res_valid       (o_valid),
        .res_stall       (i_stall),
        .res_row         (o_out_row),
        .res_col         (o_out_col),
        .res_value       (o_out_value),
        .res_last        (o_out_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .request_count   (request_count),
        .product_count   (product_count),
        .element_count   (element_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hold off the result side while a hold-off is pending, else stall at random
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold = rx_hold - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or element moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int dim_of(input logic [mm_pkg::SIZE_W-1:0] v);
        return (v == '0) ? 1 :
               ((v > mm_pkg::SIZE_W'(mm_pkg::MAX_DIM)) ? mm_pkg::MAX_DIM : int'(v));
    endfunction

    function automatic logic [15:0] random_value();
        case ($urandom_range(7))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [mm_pkg::SIZE_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return mm_pkg::SIZE_W'($urandom_range(15, mm_pkg::MAX_DIM + 1));
            2:       return mm_pkg::SIZE_W'(1);
            3:       return mm_pkg::SIZE_W'(mm_pkg::MAX_DIM);
            4:       return mm_pkg::SIZE_W'($urandom_range(mm_pkg::MAX_DIM, 1));
            default: return mm_pkg::SIZE_W'($urandom_range(4, 1));
        endcase
    endfunction

    task automatic send_request(input mm_pkg::t_cmd cmd,
                                input logic [mm_pkg::IDX_W-1:0] row,
                                input logic [mm_pkg::IDX_W-1:0] col,
                                input logic [15:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_elem_row   <= row;
        i_elem_col   <= col;
        i_elem_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_size(input mm_pkg::t_reg idx, input logic [mm_pkg::SIZE_W-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_sizes(input logic [mm_pkg::SIZE_W-1:0] r,
                             input logic [mm_pkg::SIZE_W-1:0] k,
                             input logic [mm_pkg::SIZE_W-1:0] c);
        write_size(mm_pkg::REG_ROWS_A, r);
        write_size(mm_pkg::REG_INNER_SIZE, k);
        write_size(mm_pkg::REG_COLS_B, c);
        dim_r = dim_of(r);
        dim_k = dim_of(k);
        dim_c = dim_of(c);
        size_settings++;
    endtask

    // drop valid, wait out every pending element, then let queued loads retire
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_item();
        int sel;
        mm_pkg::t_cmd cmd;
        logic [mm_pkg::IDX_W-1:0] row;
        logic [mm_pkg::IDX_W-1:0] col;
        sel = $urandom_range(99);
        row = mm_pkg::IDX_W'($urandom);
        col = mm_pkg::IDX_W'($urandom);
        if (sel < 82) begin
            if ($urandom_range(1)) begin
                cmd = mm_pkg::CMD_LOAD_B;
                row = mm_pkg::IDX_W'($urandom_range(dim_k - 1));
                col = mm_pkg::IDX_W'($urandom_range(dim_c - 1));
            end else begin
                cmd = mm_pkg::CMD_LOAD_A;
                row = mm_pkg::IDX_W'($urandom_range(dim_r - 1));
                col = mm_pkg::IDX_W'($urandom_range(dim_k - 1));
            end
        end else if (sel < 94) begin
            cmd = $urandom_range(1) ? mm_pkg::CMD_LOAD_B : mm_pkg::CMD_LOAD_A;
        end else if (sel < 97) begin
            cmd = mm_pkg::CMD_NONE;
        end else begin
            cmd = mm_pkg::CMD_COMPUTE;
        end
        send_request(cmd, row, col, random_value());
        live_items++;
    endtask

    task automatic run_segment();
        int n;
        set_sizes(pick_size(), pick_size(), pick_size());
        n = $urandom_range(30, 10);
        repeat (n) random_item();
        send_request(mm_pkg::CMD_COMPUTE, mm_pkg::IDX_W'($urandom),
                     mm_pkg::IDX_W'($urandom), random_value());
        live_items++;
        drain_results();
    endtask

    // stall the result side long enough for the request queue to fill up
    task automatic pressure_burst();
        set_sizes(mm_pkg::SIZE_W'(mm_pkg::MAX_DIM), mm_pkg::SIZE_W'(mm_pkg::MAX_DIM),
                  mm_pkg::SIZE_W'(mm_pkg::MAX_DIM));
        repeat (6) random_item();
        send_request(mm_pkg::CMD_COMPUTE, '0, '0, random_value());
        live_items++;
        rx_hold = HOLD_CYCLES;
        repeat (12) random_item();
        send_request(mm_pkg::CMD_COMPUTE, '0, '0, random_value());
        live_items++;
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 16;
        rx_idle_pct = 63;

        // cleared stores must give an all-zero product
        send_request(mm_pkg::CMD_COMPUTE, '0, '0, '0);
        drain_results();

        // largest positive and large negative sums
        set_sizes(mm_pkg::SIZE_W'(1), mm_pkg::SIZE_W'(mm_pkg::MAX_DIM), mm_pkg::SIZE_W'(2));
        for (int k = 0; k < mm_pkg::MAX_DIM; k++) begin
            send_request(mm_pkg::CMD_LOAD_A, '0, mm_pkg::IDX_W'(k), Q_MIN);
            send_request(mm_pkg::CMD_LOAD_B, mm_pkg::IDX_W'(k), '0, Q_MIN);
        end
        for (int k = 0; k < 4; k++) begin
            send_request(mm_pkg::CMD_LOAD_B, mm_pkg::IDX_W'(k), mm_pkg::IDX_W'(1), Q_MAX);
        end
        send_request(mm_pkg::CMD_COMPUTE, '1, '1, Q_MAX);
        drain_results();

        // loads just outside the sizes and the unused command are dropped
        set_sizes(mm_pkg::SIZE_W'(3), mm_pkg::SIZE_W'(2), mm_pkg::SIZE_W'(4));
        send_request(mm_pkg::CMD_LOAD_A, mm_pkg::IDX_W'(3), '0, Q_MAX);
        send_request(mm_pkg::CMD_LOAD_A, '0, mm_pkg::IDX_W'(2), Q_MAX);
        send_request(mm_pkg::CMD_LOAD_B, mm_pkg::IDX_W'(2), '0, Q_MAX);
        send_request(mm_pkg::CMD_LOAD_B, '0, mm_pkg::IDX_W'(4), Q_MAX);
        send_request(mm_pkg::CMD_NONE, '1, '1, Q_MIN);
        send_request(mm_pkg::CMD_COMPUTE, '0, '0, '0);
        drain_results();

        // zero acts as one, above the maximum acts as the maximum
        set_sizes('0, '0, '1);
        send_request(mm_pkg::CMD_COMPUTE, '0, '0, '0);
        drain_results();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 16;
                    rx_idle_pct = 63;
                end
                1: begin
                    tx_idle_pct = 63;
                    rx_idle_pct = 16;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    pressure_burst();
                end
            endcase
            while (live_items < RANDOM_ITEMS * (ph + 1) / 3) run_segment();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests over %0d size settings: %0d products, %0d elements checked",
                 request_count, size_settings, product_count, element_count);
        $display("Idle mixes: light sender/heavy receiver, reversed, none, one long hold-off");
        if (fail_count == 0 && results_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
